>>> sv/vessel_report_plausibility_check_assert.svh
// Assertion macros for the vessel report plausibility check.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef VESSEL_REPORT_PLAUSIBILITY_CHECK_ASSERT_SVH
`define VESSEL_REPORT_PLAUSIBILITY_CHECK_ASSERT_SVH

// Same-cycle implication, off during reset
`define VRPC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vrpc: same-cycle check failed");

// Next-cycle implication, off during reset
`define VRPC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vrpc: next-cycle check failed");

`endif

>>> sv/vrpc_pkg.sv
// Shared types, constants and the ship-type speed table of the plausibility check.
// No dependencies.
package vrpc_pkg;

	localparam int SLOTS = 1024;
	localparam int IDX_W = $clog2(SLOTS);

	localparam int MMSI_W = 30;
	localparam int LAT_W  = 27;
	localparam int LON_W  = 28;
	localparam int SOG_W  = 10;
	localparam int COG_W  = 12;
	localparam int HDG_W  = 9;
	localparam int NAV_W  = 4;
	localparam int TYPE_W = 8;
	localparam int TIME_W = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// serial multiplier operand and product widths
	localparam int PROD_W  = 128;
	localparam int MUL_B_W = 64;

	// squared distance widths
	localparam int OBS2_W = 85;
	localparam int SQ_W   = 106;

	localparam logic [SOG_W-1:0]  SOG_NA_MIN    = 10'd1022;
	localparam logic [SOG_W-1:0]  STILL_SOG     = 10'd3;
	localparam logic [COG_W-1:0]  COG_NA        = 12'd3600;
	localparam logic [HDG_W-1:0]  HDG_NA        = 9'd511;
	localparam logic [31:0]       JUMP_WINDOW_S = 32'd60;
	localparam logic [10:0]       KNOT_M        = 11'd1852;
	localparam logic [25:0]       OBS_SCALE     = 26'd44355600;
	localparam logic [63:0]       NEAR2         = 64'd12960000000000;
	localparam logic [23:0]       LO_MIN2       = 24'd12960000;

	localparam logic [NAV_W-1:0] NAV_ANCHORED = 4'd1;
	localparam logic [NAV_W-1:0] NAV_MOORED   = 4'd5;
	localparam logic [NAV_W-1:0] NAV_AGROUND  = 4'd6;

	typedef struct packed {
		logic              valid;
		logic [MMSI_W-1:0] tag;
		logic [LAT_W-1:0]  lat;
		logic [LON_W-1:0]  lon;
		logic [SOG_W-1:0]  sog;
		logic [TIME_W-1:0] rtime;
	} slot_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		slot_t            data;
	} tbl_wr_t;

	typedef enum logic [3:0] {
		ANOM_NONE       = 4'd0,
		ANOM_TYPE_SPEED = 4'd1,
		ANOM_ANCHORED   = 4'd2,
		ANOM_MISMATCH   = 4'd3,
		ANOM_PHYSICAL   = 4'd4,
		ANOM_JUMP       = 4'd5,
		ANOM_GAP        = 4'd6,
		ANOM_RATIO      = 4'd7,
		ANOM_STILL      = 4'd8
	} anomaly_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHYSICAL,
		REG_DEFAULT,
		REG_ANCHORED,
		REG_MIN_SOG,
		REG_ANGLE,
		REG_JUMP,
		REG_GAP,
		REG_RATIO
	} cfg_reg_t;

	// speed limit by ship and cargo type, tenths of knot
	function automatic logic [SOG_W-1:0] type_limit(input logic [TYPE_W-1:0] st,
			input logic [SOG_W-1:0] dflt);
		logic [SOG_W-1:0] lim;
		lim = dflt;
		priority if (st == 8'd30)
			lim = 10'd150;
		else if (st == 8'd31 || st == 8'd32)
			lim = 10'd120;
		else if (st == 8'd33 || st == 8'd34)
			lim = 10'd80;
		else if (st == 8'd35)
			lim = 10'd350;
		else if (st == 8'd36 || st == 8'd37)
			lim = 10'd200;
		else if (st >= 8'd60 && st <= 8'd69)
			lim = 10'd300;
		else if (st >= 8'd70 && st <= 8'd79)
			lim = 10'd250;
		else if (st >= 8'd80 && st <= 8'd89)
			lim = 10'd180;
		else
			lim = dflt;
		return lim;
	endfunction

endpackage

>>> sv/vrpc_tbl.sv
// Last-report table: synchronous memory with one read and one write port, with a clearing pass after reset.
// Depends on vrpc_pkg.
module vrpc_tbl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [vrpc_pkg::IDX_W-1:0]    rd_idx,
	output vrpc_pkg::slot_t               rd_data,
	input  vrpc_pkg::tbl_wr_t             wr,
	output logic                          busy
);

	vrpc_pkg::slot_t mem [vrpc_pkg::SLOTS];
	vrpc_pkg::slot_t rd_data_q;
	logic clearing_q;
	logic [vrpc_pkg::IDX_W-1:0] clr_idx_q;

	// sweep every slot once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1)
				clearing_q <= 1'b0;
		end
	end

	// write port and registered read
	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_idx_q] <= '0;
		else if (wr.en)
			mem[wr.idx] <= wr.data;
		if (rd_en)
			rd_data_q <= mem[rd_idx];
	end

	assign rd_data = rd_data_q;
	assign busy = clearing_q;

endmodule

>>> sv/vrpc_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, stops when the rest is zero.
// Depends on vrpc_pkg.
module vrpc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vrpc_pkg::PROD_W-1:0]   a,
	input  logic [vrpc_pkg::MUL_B_W-1:0]  b,
	output logic                          busy,
	output logic [vrpc_pkg::PROD_W-1:0]   prod
);

	logic [vrpc_pkg::PROD_W-1:0]  a_q;
	logic [vrpc_pkg::PROD_W-1:0]  acc_q;
	logic [vrpc_pkg::MUL_B_W-1:0] b_q;
	logic busy_q;

	// run until the multiplier is used up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= 1'b1;
		else if (busy_q && b_q == '0)
			busy_q <= 1'b0;
	end

	// add shifted multiplicand for each set bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

>>> sv/vessel_report_plausibility_check.sv
// Vessel report plausibility check, top level; uses vrpc_pkg, vrpc_tbl, vrpc_mul.
// Invalid reports and those settled by the table read go from the read straight to the result;
// the others pass the squaring and expected-distance steps and three runs of the shift-add
// multiplier, which works one multiplier bit per cycle.
// One request at a time: the next can be taken from the cycle in which the result shows.
// Reset: asynchronous; a clearing pass over all SLOTS (1024) table slots stalls input, config to defaults.
`include "vessel_report_plausibility_check_assert.svh"
module vessel_report_plausibility_check (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [vrpc_pkg::MMSI_W-1:0]           mmsi,
	input  logic signed [vrpc_pkg::LAT_W-1:0]     latitude,
	input  logic signed [vrpc_pkg::LON_W-1:0]     longitude,
	input  logic [vrpc_pkg::SOG_W-1:0]            sog_tenths,
	input  logic [vrpc_pkg::COG_W-1:0]            cog_tenths,
	input  logic [vrpc_pkg::HDG_W-1:0]            heading,
	input  logic [vrpc_pkg::NAV_W-1:0]            nav_status,
	input  logic [vrpc_pkg::TYPE_W-1:0]           ship_type,
	input  logic [vrpc_pkg::TIME_W-1:0]           report_time_s,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [3:0]                            anomaly,
	output logic                                  had_previous,
	output logic                                  stored,
	input  logic                                  cfg_wr_en,
	input  logic [vrpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [vrpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_SQA, S_SQB, S_E1, S_E2, S_OBS, S_OBS_W,
		S_EXP, S_EXP_W, S_SEL, S_RAT, S_RAT_W, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [9:0]  phys_q, dflt_q, anch_q, min_sog_q, jump_q;
	logic [10:0] angle_q;
	logic [16:0] gap_q;
	logic [7:0]  ratio_q;

	// request held during the check
	logic [vrpc_pkg::MMSI_W-1:0] mmsi_q;
	logic [vrpc_pkg::LAT_W-1:0]  lat_q;
	logic [vrpc_pkg::LON_W-1:0]  lon_q;
	logic [vrpc_pkg::SOG_W-1:0]  sog_q;
	logic [vrpc_pkg::COG_W-1:0]  cog_q;
	logic [vrpc_pkg::HDG_W-1:0]  hdg_q;
	logic [vrpc_pkg::NAV_W-1:0]  nav_q;
	logic [vrpc_pkg::TYPE_W-1:0] st_q;
	logic [vrpc_pkg::TIME_W-1:0] time_q;
	logic rep_ok_q, has_prev_q, dt_short_q;
	vrpc_pkg::anomaly_t anom_q;

	// working values
	logic [27:0] ala_q;
	logic [28:0] alo_q;
	logic [31:0] dt_q;
	logic [55:0] sqa_q;
	logic [58:0] d2_q;
	logic [41:0] e1_q;
	logic [52:0] e_q;
	logic [15:0] r2_q;
	logic [vrpc_pkg::OBS2_W-1:0] obs2_q;
	logic [vrpc_pkg::SQ_W-1:0]   exp2_q, hi2_q, lo2_q;

	// result register
	logic out_valid_q, out_prev_q, out_stored_q;
	vrpc_pkg::anomaly_t out_anom_q;

	// submodule wiring
	vrpc_pkg::slot_t   ent;
	vrpc_pkg::tbl_wr_t tbl_wr;
	logic tbl_busy, accept, out_free;
	logic mul_start, mul_busy;
	logic [vrpc_pkg::PROD_W-1:0]  mul_a, mul_prod;
	logic [vrpc_pkg::MUL_B_W-1:0] mul_b;

	// rule evaluation
	logic hit, sog_ok, dt_pos, dt_short, gap_hit, jump_hit, eh, ratio_hit, still_hit;
	logic [vrpc_pkg::SOG_W-1:0] lim, sog_ch;
	logic [13:0] hdg10;
	logic signed [13:0] cdiff, adiff, refl;
	logic [32:0] dt_w;
	logic [27:0] dla;
	logic [28:0] dlo;
	logic [57:0] alo_sq;
	vrpc_pkg::anomaly_t early;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || tbl_busy;
	assign out_free = !out_valid_q || !out_stall;

	vrpc_tbl u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (mmsi[vrpc_pkg::IDX_W-1:0]),
		.rd_data (ent),
		.wr      (tbl_wr),
		.busy    (tbl_busy)
	);

	vrpc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	// pick multiplier operands by step
	always_comb begin
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_OBS: begin
				mul_start = 1'b1;
				mul_a = vrpc_pkg::PROD_W'(d2_q);
				mul_b = vrpc_pkg::MUL_B_W'(vrpc_pkg::OBS_SCALE);
			end
			S_EXP: begin
				mul_start = 1'b1;
				mul_a = vrpc_pkg::PROD_W'(e_q);
				mul_b = vrpc_pkg::MUL_B_W'(e_q);
			end
			S_RAT: begin
				mul_start = 1'b1;
				mul_a = vrpc_pkg::PROD_W'(lo2_q);
				mul_b = vrpc_pkg::MUL_B_W'(r2_q);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// rules against the slot just read
	always_comb begin
		hit = ent.valid && (ent.tag == mmsi_q);
		lim = vrpc_pkg::type_limit(st_q, dflt_q);
		sog_ok = sog_q < vrpc_pkg::SOG_NA_MIN;
		hdg10 = 14'(hdg_q) * 14'd10;
		cdiff = $signed(14'(cog_q)) - $signed(hdg10);
		adiff = (cdiff < 0) ? -cdiff : cdiff;
		refl = (adiff > 14'sd1800) ? (14'sd3600 - adiff) : adiff;
		priority if (sog_ok && sog_q > lim)
			early = vrpc_pkg::ANOM_TYPE_SPEED;
		else if (sog_q >= anch_q && (nav_q == vrpc_pkg::NAV_ANCHORED
				|| nav_q == vrpc_pkg::NAV_MOORED || nav_q == vrpc_pkg::NAV_AGROUND))
			early = vrpc_pkg::ANOM_ANCHORED;
		else if (cog_q < vrpc_pkg::COG_NA && hdg_q < vrpc_pkg::HDG_NA
				&& sog_q >= min_sog_q && refl > $signed({3'b000, angle_q}))
			early = vrpc_pkg::ANOM_MISMATCH;
		else if (sog_ok && sog_q > phys_q)
			early = vrpc_pkg::ANOM_PHYSICAL;
		else
			early = vrpc_pkg::ANOM_NONE;

		dt_w = {1'b0, time_q} - {1'b0, ent.rtime};
		dt_pos = !dt_w[32] && (dt_w != '0);
		dt_short = dt_pos && (dt_w[31:0] < vrpc_pkg::JUMP_WINDOW_S);
		gap_hit = !dt_w[32] && (dt_w[31:0] > {15'b0, gap_q});
		sog_ch = (sog_q > ent.sog) ? (sog_q - ent.sog) : (ent.sog - sog_q);
		jump_hit = dt_short && (sog_ch > jump_q);

		dla = {lat_q[vrpc_pkg::LAT_W-1], lat_q} - {ent.lat[vrpc_pkg::LAT_W-1], ent.lat};
		dlo = {lon_q[vrpc_pkg::LON_W-1], lon_q} - {ent.lon[vrpc_pkg::LON_W-1], ent.lon};

		alo_sq = 58'(alo_q) * 58'(alo_q);
		eh = exp2_q >= vrpc_pkg::SQ_W'(obs2_q);
		ratio_hit = (hi2_q >= vrpc_pkg::SQ_W'(vrpc_pkg::NEAR2))
			&& (lo2_q > vrpc_pkg::SQ_W'(vrpc_pkg::LO_MIN2))
			&& (vrpc_pkg::PROD_W'(hi2_q) > mul_prod);
		still_hit = (sog_q < vrpc_pkg::STILL_SOG) && dt_short_q
			&& (obs2_q > vrpc_pkg::OBS2_W'(vrpc_pkg::NEAR2));
	end

	// store a valid report when its result is handed over
	always_comb begin
		tbl_wr.en = (state_q == S_DONE) && out_free && rep_ok_q;
		tbl_wr.idx = mmsi_q[vrpc_pkg::IDX_W-1:0];
		tbl_wr.data.valid = 1'b1;
		tbl_wr.data.tag = mmsi_q;
		tbl_wr.data.lat = lat_q;
		tbl_wr.data.lon = lon_q;
		tbl_wr.data.sog = sog_q;
		tbl_wr.data.rtime = time_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phys_q <= 10'd500;
			dflt_q <= 10'd300;
			anch_q <= 10'd15;
			min_sog_q <= 10'd30;
			angle_q <= 11'd900;
			jump_q <= 10'd200;
			gap_q <= 17'd1800;
			ratio_q <= 8'd20;
		end else if (cfg_wr_en) begin
			unique case (vrpc_pkg::cfg_reg_t'(cfg_index))
				vrpc_pkg::REG_PHYSICAL: phys_q <= cfg_data[9:0];
				vrpc_pkg::REG_DEFAULT:  dflt_q <= cfg_data[9:0];
				vrpc_pkg::REG_ANCHORED: anch_q <= cfg_data[9:0];
				vrpc_pkg::REG_MIN_SOG:  min_sog_q <= cfg_data[9:0];
				vrpc_pkg::REG_ANGLE:    angle_q <= cfg_data[10:0];
				vrpc_pkg::REG_JUMP:     jump_q <= cfg_data[9:0];
				vrpc_pkg::REG_GAP:      gap_q <= cfg_data[16:0];
				vrpc_pkg::REG_RATIO:    ratio_q <= cfg_data[7:0];
			endcase
		end
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// present the result, drop it once taken
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_READ;
				end
				S_READ: begin
					if (!rep_ok_q || early != vrpc_pkg::ANOM_NONE || !hit || jump_hit
							|| gap_hit || !dt_pos)
						state_q <= S_DONE;
					else
						state_q <= S_SQA;
				end
				S_SQA: state_q <= S_SQB;
				S_SQB: state_q <= S_E1;
				S_E1:  state_q <= S_E2;
				S_E2:  state_q <= S_OBS;
				S_OBS: state_q <= S_OBS_W;
				S_OBS_W: begin
					if (!mul_busy)
						state_q <= S_EXP;
				end
				S_EXP: state_q <= S_EXP_W;
				S_EXP_W: begin
					if (!mul_busy)
						state_q <= S_SEL;
				end
				S_SEL: state_q <= S_RAT;
				S_RAT: state_q <= S_RAT_W;
				S_RAT_W: begin
					if (!mul_busy)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mmsi_q <= mmsi;
			lat_q <= latitude;
			lon_q <= longitude;
			sog_q <= sog_tenths;
			cog_q <= cog_tenths;
			hdg_q <= heading;
			nav_q <= nav_status;
			st_q <= ship_type;
			time_q <= report_time_s;
			rep_ok_q <= (mmsi != '0) && !(latitude == '0 && longitude == '0);
		end
		unique case (state_q)
			S_READ: begin
				has_prev_q <= rep_ok_q && hit;
				ala_q <= dla[27] ? (~dla + 1'b1) : dla;
				alo_q <= dlo[28] ? (~dlo + 1'b1) : dlo;
				dt_q <= dt_w[31:0];
				dt_short_q <= dt_short;
				priority if (!rep_ok_q)
					anom_q <= vrpc_pkg::ANOM_NONE;
				else if (early != vrpc_pkg::ANOM_NONE)
					anom_q <= early;
				else if (!hit)
					anom_q <= vrpc_pkg::ANOM_NONE;
				else if (jump_hit)
					anom_q <= vrpc_pkg::ANOM_JUMP;
				else if (gap_hit)
					anom_q <= vrpc_pkg::ANOM_GAP;
				else
					anom_q <= vrpc_pkg::ANOM_NONE;
			end
			S_SQA: sqa_q <= 56'(ala_q) * 56'(ala_q);
			S_SQB: d2_q <= 59'(sqa_q) + 59'(alo_sq);
			S_E1:  e1_q <= 42'(sog_q) * 42'(dt_q);
			S_E2: begin
				e_q <= 53'(e1_q) * 53'(vrpc_pkg::KNOT_M);
				r2_q <= 16'(ratio_q) * 16'(ratio_q);
			end
			S_OBS_W: begin
				if (!mul_busy)
					obs2_q <= mul_prod[vrpc_pkg::OBS2_W-1:0];
			end
			S_EXP_W: begin
				if (!mul_busy)
					exp2_q <= mul_prod[vrpc_pkg::SQ_W-1:0];
			end
			S_SEL: begin
				hi2_q <= eh ? exp2_q : vrpc_pkg::SQ_W'(obs2_q);
				lo2_q <= eh ? vrpc_pkg::SQ_W'(obs2_q) : exp2_q;
			end
			S_RAT_W: begin
				if (!mul_busy) begin
					priority if (ratio_hit)
						anom_q <= vrpc_pkg::ANOM_RATIO;
					else if (still_hit)
						anom_q <= vrpc_pkg::ANOM_STILL;
					else
						anom_q <= vrpc_pkg::ANOM_NONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_anom_q <= anom_q;
					out_prev_q <= has_prev_q;
					out_stored_q <= rep_ok_q;
				end
			end
			default: begin
				anom_q <= anom_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign anomaly = out_anom_q;
	assign had_previous = out_prev_q;
	assign stored = out_stored_q;

	`VRPC_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
	`VRPC_ASSERT_IMPL(a_invalid_is_quiet, out_valid && !stored, anomaly == vrpc_pkg::ANOM_NONE && !had_previous)
	`VRPC_ASSERT_IMPL(a_write_at_done, tbl_wr.en, state_q == S_DONE && rep_ok_q)
	`VRPC_ASSERT_IMPL(a_mul_start_idle, mul_start, !mul_busy)
	`VRPC_ASSERT_IMPL(a_stall_while_clearing, tbl_busy, in_stall)

endmodule

>>> dv/vessel_report_plausibility_check_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for vessel_report_plausibility_check: directed and random reports.
// Expected results come from a behavioral predictor kept in this file; uses vrpc_pkg.
module vessel_report_plausibility_check_tb;

	localparam int TABLE_SLOTS = vrpc_pkg::SLOTS;
	localparam int DRAIN_CYCLES = 150;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 500;

	typedef struct {
		logic [29:0]        mmsi;
		logic signed [26:0] lat;
		logic signed [27:0] lon;
		logic [9:0]         sog;
		logic [11:0]        cog;
		logic [8:0]         hdg;
		logic [3:0]         nav;
		logic [7:0]         stype;
		logic [31:0]        rtime;
	} report_t;

	typedef struct {
		logic [3:0] anom;
		logic       had_prev;
		logic       stored;
	} verdict_t;

	typedef struct {
		bit                 valid;
		logic [29:0]        tag;
		logic signed [26:0] lat;
		logic signed [27:0] lon;
		logic [9:0]         sog;
		logic [31:0]        rtime;
	} last_fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [vrpc_pkg::MMSI_W-1:0] mmsi = '0;
	logic signed [vrpc_pkg::LAT_W-1:0] latitude = '0;
	logic signed [vrpc_pkg::LON_W-1:0] longitude = '0;
	logic [vrpc_pkg::SOG_W-1:0] sog_tenths = '0;
	logic [vrpc_pkg::COG_W-1:0] cog_tenths = '0;
	logic [vrpc_pkg::HDG_W-1:0] heading = '0;
	logic [vrpc_pkg::NAV_W-1:0] nav_status = '0;
	logic [vrpc_pkg::TYPE_W-1:0] ship_type = '0;
	logic [vrpc_pkg::TIME_W-1:0] report_time_s = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] anomaly;
	logic had_previous;
	logic stored;
	logic cfg_wr_en = 1'b0;
	logic [vrpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vrpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	last_fix_t last_fix[TABLE_SLOTS];
	logic [9:0] lim_phys, lim_default, lim_anchor, lim_min_sog, lim_jump;
	logic [10:0] lim_angle;
	logic [16:0] lim_gap;
	logic [7:0] lim_ratio;

	verdict_t pending_verdicts[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;

	// fleet for well-formed tracks
	localparam int FLEET = 24;
	logic [29:0] fleet_mmsi[FLEET];
	logic signed [26:0] fleet_lat[FLEET];
	logic signed [27:0] fleet_lon[FLEET];
	logic [31:0] fleet_time[FLEET];

	vessel_report_plausibility_check u_dut (.*);

	always #2 clk = ~clk;

	function automatic logic [9:0] speed_cap(logic [7:0] st);
		if (st == 30) return 10'd150;
		if (st == 31 || st == 32) return 10'd120;
		if (st == 33 || st == 34) return 10'd80;
		if (st == 35) return 10'd350;
		if (st == 36 || st == 37) return 10'd200;
		if (st >= 60 && st <= 69) return 10'd300;
		if (st >= 70 && st <= 79) return 10'd250;
		if (st >= 80 && st <= 89) return 10'd180;
		return lim_default;
	endfunction

	// rule chain, first hit wins
	function automatic vrpc_pkg::anomaly_t grade_report(report_t r, last_fix_t p, bit hp);
		int d;
		longint dt, dla, dlo;
		logic [63:0] ala, alo, e;
		logic [127:0] obs2, exp2, hi2, lo2;
		logic [31:0] rsq;
		logic [9:0] ch;
		if (r.sog < 1022 && r.sog > speed_cap(r.stype)) return vrpc_pkg::ANOM_TYPE_SPEED;
		if (r.sog >= lim_anchor && (r.nav == vrpc_pkg::NAV_ANCHORED ||
				r.nav == vrpc_pkg::NAV_MOORED || r.nav == vrpc_pkg::NAV_AGROUND))
			return vrpc_pkg::ANOM_ANCHORED;
		if (r.cog < 3600 && r.hdg < 511 && r.sog >= lim_min_sog) begin
			d = int'(r.cog) - int'(r.hdg) * 10;
			if (d < 0) d = -d;
			if (d > 1800) d = 3600 - d;
			if (d > int'(lim_angle)) return vrpc_pkg::ANOM_MISMATCH;
		end
		if (r.sog < 1022 && r.sog > lim_phys) return vrpc_pkg::ANOM_PHYSICAL;
		if (!hp) return vrpc_pkg::ANOM_NONE;
		dt = longint'(r.rtime) - longint'(p.rtime);
		if (dt > 0 && dt < 60) begin
			ch = r.sog > p.sog ? r.sog - p.sog : p.sog - r.sog;
			if (ch > lim_jump) return vrpc_pkg::ANOM_JUMP;
		end
		if (dt > longint'(lim_gap)) return vrpc_pkg::ANOM_GAP;
		dla = longint'(r.lat) - longint'(p.lat);
		dlo = longint'(r.lon) - longint'(p.lon);
		ala = dla < 0 ? -dla : dla;
		alo = dlo < 0 ? -dlo : dlo;
		obs2 = (128'(ala) * 128'(ala) + 128'(alo) * 128'(alo)) * 128'd44355600;
		if (dt > 0) begin
			e = 64'(r.sog) * 64'(dt) * 64'd1852;
			exp2 = 128'(e) * 128'(e);
			hi2 = exp2 >= obs2 ? exp2 : obs2;
			lo2 = exp2 >= obs2 ? obs2 : exp2;
			rsq = 32'(lim_ratio) * 32'(lim_ratio);
			if (hi2 >= 128'd12960000000000 && lo2 > 128'd12960000 && hi2 > lo2 * 128'(rsq))
				return vrpc_pkg::ANOM_RATIO;
		end
		if (r.sog < 3 && dt > 0 && dt < 60 && obs2 > 128'd12960000000000)
			return vrpc_pkg::ANOM_STILL;
		return vrpc_pkg::ANOM_NONE;
	endfunction

	// work out the verdict and update the table
	function automatic verdict_t judge_report(report_t r);
		verdict_t v;
		int slot;
		bit hp;
		v = '{default: 0};
		if (r.mmsi == 0 || (r.lat == 0 && r.lon == 0)) return v;
		slot = r.mmsi % TABLE_SLOTS;
		hp = last_fix[slot].valid && last_fix[slot].tag == r.mmsi;
		v.anom = grade_report(r, last_fix[slot], hp);
		v.had_prev = hp;
		v.stored = 1'b1;
		last_fix[slot] = '{1'b1, r.mmsi, r.lat, r.lon, r.sog, r.rtime};
		return v;
	endfunction

	function automatic report_t mk(int m, int la, int lo, int s, int c, int h, int n,
			int st, logic [31:0] t);
		report_t r;
		r = '{30'(m), 27'(la), 28'(lo), 10'(s), 12'(c), 9'(h), 4'(n), 8'(st), t};
		return r;
	endfunction

	// offer one request and wait for it to be taken
	task automatic send_report(report_t r);
		verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mmsi <= r.mmsi;
		latitude <= r.lat;
		longitude <= r.lon;
		sog_tenths <= r.sog;
		cog_tenths <= r.cog;
		heading <= r.hdg;
		nav_status <= r.nav;
		ship_type <= r.stype;
		report_time_s <= r.rtime;
		do @(posedge clk); while (in_stall);
		v = judge_report(r);
		pending_verdicts = {pending_verdicts, v};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(vrpc_pkg::cfg_reg_t idx, logic [16:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			vrpc_pkg::REG_PHYSICAL: lim_phys = val[9:0];
			vrpc_pkg::REG_DEFAULT:  lim_default = val[9:0];
			vrpc_pkg::REG_ANCHORED: lim_anchor = val[9:0];
			vrpc_pkg::REG_MIN_SOG:  lim_min_sog = val[9:0];
			vrpc_pkg::REG_ANGLE:    lim_angle = val[10:0];
			vrpc_pkg::REG_JUMP:     lim_jump = val[9:0];
			vrpc_pkg::REG_GAP:      lim_gap = val[16:0];
			vrpc_pkg::REG_RATIO:    lim_ratio = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(int ph, int df, int an, int ms, int ag, int jp, int gp, int rt);
		write_reg(vrpc_pkg::REG_PHYSICAL, 17'(ph));
		write_reg(vrpc_pkg::REG_DEFAULT, 17'(df));
		write_reg(vrpc_pkg::REG_ANCHORED, 17'(an));
		write_reg(vrpc_pkg::REG_MIN_SOG, 17'(ms));
		write_reg(vrpc_pkg::REG_ANGLE, 17'(ag));
		write_reg(vrpc_pkg::REG_JUMP, 17'(jp));
		write_reg(vrpc_pkg::REG_GAP, 17'(gp));
		write_reg(vrpc_pkg::REG_RATIO, 17'(rt));
	endtask

	// build a report: mostly a plausible next fix of a fleet vessel, some noise
	function automatic report_t random_report();
		report_t r;
		int k, pick, dt, s, scale;
		k = $urandom_range(FLEET - 1);
		pick = $urandom_range(99);
		if (pick < 8) begin
			r = '{30'($urandom), 27'($urandom), 28'($urandom), 10'($urandom),
				12'($urandom), 9'($urandom), 4'($urandom), 8'($urandom), $urandom};
			return r;
		end
		case ($urandom_range(9))
			0: dt = $urandom_range(1, 100000);
			1: dt = -$urandom_range(0, 50);
			default: dt = $urandom_range(1, 90);
		endcase
		s = $urandom_range(3) == 0 ? $urandom_range(1023) :
			($urandom_range(3) == 0 ? $urandom_range(2) : $urandom_range(5, 250));
		scale = $urandom_range(4) == 0 ? $urandom_range(0, 200) : $urandom_range(3, 5);
		r.mmsi = fleet_mmsi[k];
		r.lat = fleet_lat[k] + 27'(((s * (dt > 0 ? dt : 1) * scale) / 18) % 2000000);
		r.lon = fleet_lon[k] - 28'($urandom_range(0, 50));
		r.sog = 10'(s);
		r.cog = $urandom_range(9) == 0 ? 12'($urandom_range(3600, 4095)) :
			12'($urandom_range(3599));
		r.hdg = $urandom_range(7) == 0 ? 9'($urandom_range(360, 511)) :
			9'((r.cog / 10 + $urandom_range(0, 120)) % 360);
		r.nav = $urandom_range(5) == 0 ? 4'($urandom_range(15)) : 4'd0;
		r.stype = 8'($urandom_range(255));
		if ($urandom_range(3) == 0) r.stype = 8'($urandom_range(30, 89));
		r.rtime = fleet_time[k] + 32'(dt);
		if (pick < 12) r.mmsi = fleet_mmsi[k] ^ 30'(TABLE_SLOTS << $urandom_range(0, 19));
		fleet_lat[k] = r.lat;
		fleet_lon[k] = r.lon;
		fleet_time[k] = r.rtime;
		return r;
	endfunction

	task automatic run_random(int n);
		repeat (n) send_report(random_report());
	endtask

	task automatic test_directed();
		int a;
		a = 123456789;
		send_report(mk(0, 1000, 1000, 10, 0, 0, 0, 0, 5));
		send_report(mk(a, 0, 0, 10, 0, 0, 0, 0, 5));
		send_report(mk(a, 1000000, 2000000, 100, 900, 90, 0, 0, 1000));
		send_report(mk(a, 1000000, 2000000, 1023, 900, 90, 0, 0, 1010));
		send_report(mk(a, 1000000, 2000000, 100, 900, 90, 0, 0, 1010));
		send_report(mk(a, 1000000, 2000000, 100, 900, 90, 0, 0, 5000));
		send_report(mk(a, 1100000, 2000000, 1, 900, 90, 0, 0, 5001));
		send_report(mk(a, 1100010, 2000000, 100, 900, 90, 0, 0, 5061));
		send_report(mk(a, 1100010, 2000000, 100, 900, 90, 0, 0, 4000));
		send_report(mk(a + TABLE_SLOTS, 1100010, 2000000, 100, 900, 90, 0, 0, 4010));
		send_report(mk(11, 5, 5, 160, 0, 0, 0, 30, 1));
		send_report(mk(12, 5, 5, 340, 0, 0, 0, 35, 1));
		send_report(mk(13, 5, 5, 20, 0, 0, 5, 60, 1));
		send_report(mk(14, 5, 5, 15, 0, 0, 6, 70, 1));
		send_report(mk(15, 5, 5, 14, 0, 0, 1, 80, 1));
		send_report(mk(16, 5, 5, 50, 0, 180, 0, 33, 1));
		send_report(mk(17, 5, 5, 50, 3599, 0, 0, 31, 1));
		send_report(mk(18, 5, 5, 50, 100, 400, 0, 36, 1));
		send_report(mk(19, 5, 5, 50, 4095, 0, 0, 0, 1));
		send_report(mk(20, 5, 5, 50, 0, 511, 0, 0, 1));
		send_report(mk(999999999, -54600000, 108600000, 1022, 3600, 0, 15, 255, '1));
		send_report(mk(999999999, 54600000, -108600000, 0, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_config_extremes();
		write_all(0, 0, 0, 0, 0, 0, 0, 0);
		run_random(40);
		drain();
		write_all(1023, 1023, 1023, 1023, 1800, 1023, 86400, 255);
		run_random(40);
		drain();
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 16;
		recv_stall_pct = 71;
		write_all(500, 300, 15, 30, 900, 200, 1800, 20);
		run_random(130);
		drain();
		send_idle_pct = 71;
		recv_stall_pct = 16;
		write_all($urandom_range(100, 400), $urandom_range(1023), $urandom_range(40),
			$urandom_range(60), $urandom_range(1800), $urandom_range(300),
			$urandom_range(10, 5000), $urandom_range(1, 255));
		run_random(130);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_all(500, 300, 15, 30, 900, 200, 1800, 1);
		run_random(130);
		drain();
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		run_random(40);
		drain();
	endtask

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(99) < recv_stall_pct;
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: anomaly %0d had_previous %0d stored %0d",
						anomaly, had_previous, stored);
			end else begin
				want = pending_verdicts.pop_front();
				if (anomaly !== want.anom || had_previous !== want.had_prev ||
						stored !== want.stored) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							want.anom, want.had_prev, want.stored,
							anomaly, had_previous, stored);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("vessel_report_plausibility_check_tb: done, errors");
			$finish;
		end
	end

	initial begin
		foreach (last_fix[i]) last_fix[i] = '{default: 0};
		lim_phys = 500;
		lim_default = 300;
		lim_anchor = 15;
		lim_min_sog = 30;
		lim_angle = 900;
		lim_jump = 200;
		lim_gap = 1800;
		lim_ratio = 20;
		for (int i = 0; i < FLEET; i++) begin
			fleet_mmsi[i] = 30'($urandom_range(1, 999999999));
			fleet_lat[i] = 27'($urandom_range(0, 100000000)) - 27'sd50000000;
			fleet_lon[i] = 28'($urandom_range(0, 200000000)) - 28'sd100000000;
			fleet_time[i] = $urandom;
		end
		send_idle_pct = 16;
		recv_stall_pct = 71;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_traffic();
		test_backpressure();
		if (mismatches == 0)
			$display("vessel_report_plausibility_check_tb: done, clean");
		else
			$display("vessel_report_plausibility_check_tb: done, errors");
		$finish;
	end

endmodule
